/* design/mbr_pkg.sv */
package mbr_pkg;

	localparam int TABLE_POINTS = 12;
	localparam int NUM_SEG = TABLE_POINTS - 1;
	localparam int SEG_W = $clog2(NUM_SEG);
	localparam int T_W = 5;
	localparam int TABLE_FRAC = 20;
	localparam int RATIO_TAB_W = 21;
	localparam int NUM_W = 25;
	localparam int DELTA_W = 22;
	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

	// Calibration points: power level and left/right ratio in Q1.20.
	localparam logic [7:0] LEVEL [TABLE_POINTS] = '{
		8'd70, 8'd80, 8'd90, 8'd100, 8'd110, 8'd120,
		8'd140, 8'd160, 8'd180, 8'd200, 8'd225, 8'd255
	};

	localparam logic [RATIO_TAB_W-1:0] RATIO_Q20 [TABLE_POINTS] = '{
		21'd1053473, 21'd1036381, 21'd1051135, 21'd1040376,
		21'd1033214, 21'd1052833, 21'd1054951, 21'd1047622,
		21'd1018461, 21'd1020160, 21'd996850, 21'd920786
	};

	localparam logic [7:0] MIN_POWER = 8'd70;
	localparam logic [7:0] MAX_POWER = 8'd255;

	typedef struct packed {
		logic [7:0]       power;
		logic [SEG_W-1:0] seg;
		logic [T_W-1:0]   offset;
	} item_t;

endpackage

/* design/mbr_front.sv */
module mbr_front (
	input  logic          [7:0] requested_power,
	output mbr_pkg::item_t      item
);
	import mbr_pkg::*;

	logic [7:0]       power_cl;
	logic [SEG_W-1:0] seg;

	always_comb begin
		power_cl = requested_power;
		if (requested_power < LEVEL[0]) begin
			power_cl = LEVEL[0];
		end else if (requested_power > LEVEL[TABLE_POINTS-1]) begin
			power_cl = LEVEL[TABLE_POINTS-1];
		end
		seg = '0;
		for (int i = 1; i < TABLE_POINTS - 1; i++) begin
			if (power_cl >= LEVEL[i]) begin
				seg = SEG_W'(i);
			end
		end
	end

	always_comb begin
		item.power = power_cl;
		item.seg = seg;
		item.offset = T_W'(power_cl - LEVEL[seg]);
	end

endmodule

/* design/mbr_queue.sv */
module mbr_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  mbr_pkg::item_t item_in,
	output logic           full,
	input  logic           pop,
	output logic           nonempty,
	output mbr_pkg::item_t item_out
);
	import mbr_pkg::*;

	item_t                  entry_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0] wr_ptr_q;
	logic [QUEUE_PTR_W-1:0] rd_ptr_q;
	logic [QUEUE_CNT_W-1:0] count_q;
	logic                   wr_en;
	logic                   rd_en;

	assign full = (count_q == QUEUE_CNT_W'(QUEUE_DEPTH));
	assign nonempty = (count_q != '0);
	assign wr_en = push && !full;
	assign rd_en = pop && nonempty;
	assign item_out = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			entry_q[wr_ptr_q] <= item_in;
		end
	end

endmodule

/* design/mbr_back.sv */
module mbr_back #(
	parameter int RATIO_FRACTION_BITS = 15
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           head_valid,
	input  mbr_pkg::item_t head,
	output logic           take,
	input  logic           pop,
	output logic           empty,
	output logic [7:0]     power_a,
	output logic [7:0]     power_b,
	output logic [15:0]    balance_ratio,
	output logic [8:0]     average_twice
);
	import mbr_pkg::*;

	localparam int F = RATIO_FRACTION_BITS;
	localparam int XW = NUM_W + F + 1;
	localparam int YW = XW - TABLE_FRAC;
	localparam int QW = F + 1;
	localparam int PW = NUM_W + 3;

	logic        [NUM_W-1:0]   base_tab  [NUM_SEG];
	logic signed [DELTA_W-1:0] delta_tab [NUM_SEG];
	logic        [T_W-1:0]     len_tab   [NUM_SEG];
	logic        [YW-1:0]      recip_tab [NUM_SEG];

	for (genvar g = 0; g < NUM_SEG; g++) begin : g_seg
		localparam int SEG_LEN = int'(LEVEL[g+1]) - int'(LEVEL[g]);
		localparam logic [YW-1:0] RECIP = YW'((64'd1 << YW) / SEG_LEN);
		assign len_tab[g] = T_W'(SEG_LEN);
		assign recip_tab[g] = RECIP;
		assign base_tab[g] = NUM_W'(64'(SEG_LEN) * 64'(RATIO_Q20[g]));
		assign delta_tab[g] = DELTA_W'($signed({1'b0, RATIO_Q20[g+1]})
			- $signed({1'b0, RATIO_Q20[g]}));
	end

	logic             adv;
	logic             v_s1, v_s2, v_s3, v_s4, out_valid_q;
	logic [7:0]       power_s1, power_s2, power_s3, power_s4, power_q;
	logic [SEG_W-1:0] seg_s1, seg_s2, seg_s3;
	logic [NUM_W-1:0] num_s1;
	logic [YW-1:0]    y_s2, y_s3;
	logic [QW-1:0]    quot_s3, ratio_s4, ratio_q;
	logic [8:0]       pb_raw_q;

	logic signed [PW-1:0] term;
	logic signed [PW-1:0] num_sum;
	logic [XW-1:0]        x_val;
	logic [2*YW-1:0]      recip_prod;
	logic [YW-1:0]        back_prod;
	logic [YW-1:0]        rem;
	logic [QW-1:0]        ratio_d;
	logic [QW+7:0]        power_prod;

	assign adv = !out_valid_q || pop;
	assign take = adv && head_valid;

	assign term = PW'($signed({1'b0, head.offset})) * PW'(delta_tab[head.seg]);
	assign num_sum = $signed({3'b000, base_tab[head.seg]}) + term;
	assign x_val = (XW'(num_s1) << F) + (XW'(len_tab[seg_s1]) << (TABLE_FRAC - 1));
	assign recip_prod = (2*YW)'(y_s2) * (2*YW)'(recip_tab[seg_s2]);
	assign back_prod = YW'(quot_s3) * YW'(len_tab[seg_s3]);
	assign rem = y_s3 - back_prod;
	assign ratio_d = quot_s3 + QW'(rem >= YW'(len_tab[seg_s3]));
	assign power_prod = (QW+8)'(power_s4) * (QW+8)'(ratio_s4);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1 <= head_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			out_valid_q <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			power_s1 <= head.power;
			seg_s1 <= head.seg;
			num_s1 <= num_sum[NUM_W-1:0];
			power_s2 <= power_s1;
			seg_s2 <= seg_s1;
			y_s2 <= x_val[XW-1:TABLE_FRAC];
			power_s3 <= power_s2;
			seg_s3 <= seg_s2;
			y_s3 <= y_s2;
			quot_s3 <= recip_prod[YW +: QW];
			power_s4 <= power_s3;
			ratio_s4 <= ratio_d;
			power_q <= power_s4;
			ratio_q <= ratio_s4;
			pb_raw_q <= power_prod[F +: 9];
		end
	end

	assign empty = !out_valid_q;
	assign power_a = power_q;
	assign balance_ratio = 16'(ratio_q);
	assign average_twice = 9'({1'b0, power_q} + pb_raw_q);

	always_comb begin
		if (pb_raw_q > {1'b0, MAX_POWER}) begin
			power_b = MAX_POWER;
		end else if (pb_raw_q < {1'b0, MIN_POWER}) begin
			power_b = MIN_POWER;
		end else begin
			power_b = pb_raw_q[7:0];
		end
	end

endmodule

/* design/motor_balance_ratio_interpolator.sv */
// Each request is a power byte raised to at least 70. The block finds its
// segment in a 12-point calibration table, interpolates the left/right ratio
// with round-half-up, and returns both drive levels, the ratio and twice the
// average power. It accepts one request per clock cycle while full is low and
// returns one result per cycle while pop is held. A request leaves the queue
// and passes through the five registered stages of the arithmetic pipeline
// (segment blend, scaling, reciprocal multiply, remainder correction, power
// multiply). A two-entry queue sits between classification and the pipeline;
// the pipeline holds while its result register waits to be popped.
module motor_balance_ratio_interpolator #(
	parameter int RATIO_FRACTION_BITS = 15
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  requested_power,
	output logic        empty,
	input  logic        pop,
	output logic [7:0]  power_a,
	output logic [7:0]  power_b,
	output logic [15:0] balance_ratio,
	output logic [8:0]  average_twice
);
	import mbr_pkg::*;

	item_t front_item;
	item_t head_item;
	logic  head_valid;
	logic  take;

	mbr_front u_front (
		.requested_power(requested_power),
		.item(front_item)
	);

	mbr_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.item_in(front_item),
		.full(full),
		.pop(take),
		.nonempty(head_valid),
		.item_out(head_item)
	);

	mbr_back #(
		.RATIO_FRACTION_BITS(RATIO_FRACTION_BITS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head_valid(head_valid),
		.head(head_item),
		.take(take),
		.pop(pop),
		.empty(empty),
		.power_a(power_a),
		.power_b(power_b),
		.balance_ratio(balance_ratio),
		.average_twice(average_twice)
	);

endmodule

/* design/mbr_checker.sv */
module mbr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        push,
	input logic        full,
	input logic [7:0]  requested_power,
	input logic        empty,
	input logic        pop,
	input logic [7:0]  power_a,
	input logic [7:0]  power_b,
	input logic [15:0] balance_ratio,
	input logic [8:0]  average_twice
);

	// A result that is not taken stays on the ports unchanged.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(power_a) && $stable(power_b)
			&& $stable(balance_ratio) && $stable(average_twice))
		else $error("result changed while waiting to be popped");

	a_power_a_min: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> power_a >= 8'd70)
		else $error("power_a below minimum");

	a_power_b_min: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> power_b >= 8'd70)
		else $error("power_b below minimum");

	// When power B is not saturated, the sum uses the same value.
	a_average: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && power_b != 8'd70 && power_b != 8'd255
			|-> average_twice == 9'({1'b0, power_a} + {1'b0, power_b}))
		else $error("average_twice does not match the drive levels");

endmodule

bind motor_balance_ratio_interpolator mbr_checker u_mbr_checker (.*);
